### rtl/core/ps2a_pkg.sv
// Shared types, scan codes and character lookup tables for the PS/2 set 2 decoder.
package ps2a_pkg;

  typedef logic [7:0] scan_t;
  typedef logic [1:0] act_t;
  typedef logic [6:0] char_t;

  // Key actions carried on the result channel.
  localparam act_t ACT_PRINT   = 2'd0;
  localparam act_t ACT_NEWLINE = 2'd1;
  localparam act_t ACT_BACK    = 2'd2;

  // Scan code set 2 bytes with special handling.
  localparam scan_t CODE_BREAK     = 8'hF0;
  localparam scan_t CODE_EXTEND    = 8'hE0;
  localparam scan_t CODE_LSHIFT    = 8'h12;
  localparam scan_t CODE_RSHIFT    = 8'h59;
  localparam scan_t CODE_CAPS      = 8'h58;
  localparam scan_t CODE_ENTER     = 8'h5A;
  localparam scan_t CODE_CTRL      = 8'h14;
  localparam scan_t CODE_BACKSPACE = 8'h66;

  // ASCII range of the decimal digits.
  localparam char_t CHAR_ZERO = 7'd48;
  localparam char_t CHAR_NINE = 7'd57;

  // Unshifted character for a scan code; 0 when the code has no character.
  function automatic char_t plain_char(input scan_t code);
    char_t ch;
    ch = 7'd0;
    case (code)
      8'h1C: ch = 7'h61;  8'h32: ch = 7'h62;  8'h21: ch = 7'h63;  8'h23: ch = 7'h64;
      8'h24: ch = 7'h65;  8'h2B: ch = 7'h66;  8'h34: ch = 7'h67;  8'h33: ch = 7'h68;
      8'h43: ch = 7'h69;  8'h3B: ch = 7'h6A;  8'h42: ch = 7'h6B;  8'h4B: ch = 7'h6C;
      8'h3A: ch = 7'h6D;  8'h31: ch = 7'h6E;  8'h44: ch = 7'h6F;  8'h4D: ch = 7'h70;
      8'h15: ch = 7'h71;  8'h2D: ch = 7'h72;  8'h1B: ch = 7'h73;  8'h2C: ch = 7'h74;
      8'h3C: ch = 7'h75;  8'h2A: ch = 7'h76;  8'h1D: ch = 7'h77;  8'h22: ch = 7'h78;
      8'h35: ch = 7'h79;  8'h1A: ch = 7'h7A;  8'h29: ch = 7'h20;
      8'h45: ch = 7'h30;  8'h16: ch = 7'h31;  8'h1E: ch = 7'h32;  8'h26: ch = 7'h33;
      8'h25: ch = 7'h34;  8'h2E: ch = 7'h35;  8'h36: ch = 7'h36;  8'h3D: ch = 7'h37;
      8'h3E: ch = 7'h38;  8'h46: ch = 7'h39;
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

  // Shifted character: upper case letters and the digit-row symbols.
  function automatic char_t upper_char(input scan_t code);
    char_t ch;
    ch = 7'd0;
    case (code)
      8'h1C: ch = 7'h41;  8'h32: ch = 7'h42;  8'h21: ch = 7'h43;  8'h23: ch = 7'h44;
      8'h24: ch = 7'h45;  8'h2B: ch = 7'h46;  8'h34: ch = 7'h47;  8'h33: ch = 7'h48;
      8'h43: ch = 7'h49;  8'h3B: ch = 7'h4A;  8'h42: ch = 7'h4B;  8'h4B: ch = 7'h4C;
      8'h3A: ch = 7'h4D;  8'h31: ch = 7'h4E;  8'h44: ch = 7'h4F;  8'h4D: ch = 7'h50;
      8'h15: ch = 7'h51;  8'h2D: ch = 7'h52;  8'h1B: ch = 7'h53;  8'h2C: ch = 7'h54;
      8'h3C: ch = 7'h55;  8'h2A: ch = 7'h56;  8'h1D: ch = 7'h57;  8'h22: ch = 7'h58;
      8'h35: ch = 7'h59;  8'h1A: ch = 7'h5A;  8'h29: ch = 7'h20;
      8'h45: ch = 7'h29;  8'h16: ch = 7'h21;  8'h1E: ch = 7'h40;  8'h26: ch = 7'h23;
      8'h25: ch = 7'h24;  8'h2E: ch = 7'h25;  8'h36: ch = 7'h5E;  8'h3D: ch = 7'h26;
      8'h3E: ch = 7'h2A;  8'h46: ch = 7'h28;
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/ps2_set2_scancode_to_ascii.sv
// PS/2 scan code set 2 byte decoder that turns keyboard bytes into key actions.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_scan_byte
//   out_     output     out_valid/out_ready  out_action, out_char_code
//
// One byte is taken per cycle while in_ready is high. A byte sits in the input
// register, where the table lookup and flag update happen, and its action (if any)
// then moves into the output register.
// Bytes that give no action retire from the input register without waiting
// on the output side. A stalled output only blocks a byte that gives an action.
// Reset clears the break, shift and caps flags and both valid bits.
module ps2_set2_scancode_to_ascii (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ps2a_pkg::scan_t   in_scan_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output ps2a_pkg::act_t    out_action,
  output ps2a_pkg::char_t   out_char_code
);
  import ps2a_pkg::*;

  logic  s1_valid_r;
  scan_t s1_byte_r;
  logic  break_pending_r, break_pending_nxt;
  logic  shift_held_r, shift_held_nxt;
  logic  caps_on_r, caps_on_nxt;
  logic  out_valid_r;
  act_t  out_action_r;
  char_t out_char_r;

  logic  s1_emit;
  act_t  s1_action;
  char_t s1_char;
  char_t plain_ch;
  char_t upper_ch;
  logic  out_free;
  logic  s1_adv;
  logic  in_fire;

  // Decode the registered byte against the current flags.
  always_comb begin
    plain_ch          = plain_char(s1_byte_r);
    upper_ch          = upper_char(s1_byte_r);
    s1_emit           = 1'b0;
    s1_action         = ACT_PRINT;
    s1_char           = 7'd0;
    break_pending_nxt = break_pending_r;
    shift_held_nxt    = shift_held_r;
    caps_on_nxt       = caps_on_r;
    if (break_pending_r) begin
      break_pending_nxt = 1'b0;
      if (s1_byte_r == CODE_LSHIFT || s1_byte_r == CODE_RSHIFT) begin
        shift_held_nxt = 1'b0;
      end
    end else if (s1_byte_r == CODE_BREAK) begin
      break_pending_nxt = 1'b1;
    end else if (s1_byte_r == CODE_EXTEND || s1_byte_r == CODE_CTRL) begin
      // Swallowed without effect.
    end else if (s1_byte_r == CODE_LSHIFT || s1_byte_r == CODE_RSHIFT) begin
      shift_held_nxt = 1'b1;
    end else if (s1_byte_r == CODE_CAPS) begin
      caps_on_nxt = ~caps_on_r;
    end else if (s1_byte_r == CODE_ENTER) begin
      s1_emit   = 1'b1;
      s1_action = ACT_NEWLINE;
    end else if (s1_byte_r == CODE_BACKSPACE) begin
      s1_emit   = 1'b1;
      s1_action = ACT_BACK;
    end else begin
      s1_emit = 1'b1;
      if (shift_held_r) begin
        s1_char = upper_ch;
      end else if (caps_on_r) begin
        // Caps lock leaves digits alone and raises letters.
        s1_char = (plain_ch inside {[CHAR_ZERO:CHAR_NINE]}) ? plain_ch : upper_ch;
      end else begin
        s1_char = plain_ch;
      end
    end
  end

  // Handshake between the input register and the output register.
  assign out_free = ~out_valid_r | out_ready;
  assign s1_adv   = s1_valid_r & (~s1_emit | out_free);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign in_fire  = in_valid & in_ready;

  // Input register and decoder flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      break_pending_r <= 1'b0;
      shift_held_r    <= 1'b0;
      caps_on_r       <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        break_pending_r <= break_pending_nxt;
        shift_held_r    <= shift_held_nxt;
        caps_on_r       <= caps_on_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_scan_byte;
    end
  end

  // Output register holding one finished item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv & s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && s1_emit) begin
      out_action_r <= s1_action;
      out_char_r   <= s1_char;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_action    = out_action_r;
  assign out_char_code = out_char_r;

endmodule
